// ----- sv/arfa_pkg.sv -----
`default_nettype none
package arfa_pkg;
    localparam int unsigned DataW = 64;
    localparam int unsigned OpW = 4;
    localparam int unsigned ViewW = 3;

    localparam logic [OpW-1:0] OpAnd = 4'd0;
    localparam logic [OpW-1:0] OpOr  = 4'd1;
    localparam logic [OpW-1:0] OpXor = 4'd2;
    localparam logic [OpW-1:0] OpShl = 4'd3;
    localparam logic [OpW-1:0] OpShr = 4'd4;
    localparam logic [OpW-1:0] OpAdd = 4'd5;
    localparam logic [OpW-1:0] OpSub = 4'd6;
    localparam logic [OpW-1:0] OpMul = 4'd7;
    localparam logic [OpW-1:0] OpDiv = 4'd8;
    localparam logic [OpW-1:0] OpMod = 4'd9;
    localparam logic [OpW-1:0] OpMov = 4'd10;
    localparam logic [OpW-1:0] OpDec = 4'd11;
    localparam logic [OpW-1:0] OpInc = 4'd12;
    localparam logic [OpW-1:0] OpNot = 4'd13;

    localparam logic [ViewW-1:0] ViewFull = 3'd0;
    localparam logic [ViewW-1:0] ViewLow32 = 3'd1;
    localparam logic [ViewW-1:0] ViewLow16 = 3'd2;
    localparam logic [ViewW-1:0] ViewLow8 = 3'd3;
    localparam logic [ViewW-1:0] ViewHigh8 = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture item and read operands
        logic mul_step;  // accumulate one 16-bit slice of the product
        logic div_step;  // one quotient bit
        logic finish;    // compute result and write back
    } arfa_cmd_t;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_by_zero;
    } arfa_sts_t;

    function automatic logic [DataW-1:0] view_mask(input logic [ViewW-1:0] v);
        case (v)
            ViewFull: view_mask = {DataW{1'b1}};
            ViewLow32: view_mask = 64'h0000_0000_FFFF_FFFF;
            ViewLow16: view_mask = 64'h0000_0000_0000_FFFF;
            default: view_mask = 64'h0000_0000_0000_00FF;
        endcase
    endfunction

    function automatic logic [3:0] view_shift(input logic [ViewW-1:0] v);
        view_shift = (v >= ViewHigh8) ? 4'd8 : 4'd0;
    endfunction
endpackage
`default_nettype wire

// ----- sv/arfa_ctrl.sv -----
`default_nettype none
module arfa_ctrl (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_fire,
    input  wire logic out_busy,
    input  wire arfa_pkg::arfa_sts_t sts,
    output arfa_pkg::arfa_cmd_t cmd,
    output logic in_ready,
    output logic out_load
);
    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_MUL, S_DIV, S_FINISH, S_OUT} state_t;
    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cnt_next = '0;
                if (sts.is_mul) state_next = S_MUL;
                else if (sts.is_div && !sts.div_by_zero) state_next = S_DIV;
                else state_next = S_FINISH;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3) state_next = S_FINISH;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) state_next = S_FINISH;
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!out_busy) begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ----- sv/arfa_dp.sv -----
`default_nettype none
module arfa_dp #(
    parameter int unsigned NUM_REGS = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire arfa_pkg::arfa_cmd_t cmd,
    input  wire logic [3:0] op,
    input  wire logic [1:0] dst_reg,
    input  wire logic [2:0] dst_view,
    input  wire logic [1:0] src_reg,
    input  wire logic [2:0] src_view,
    output arfa_pkg::arfa_sts_t sts,
    output logic [63:0] res_value,
    output logic res_err
);
    logic [63:0] rf_reg [NUM_REGS];
    logic [3:0] op_reg;
    logic [1:0] dr_reg;
    logic [2:0] dv_reg;
    logic [63:0] a_reg, b_reg, acc_reg, rem_reg, quo_reg;
    logic [63:0] a_rd, b_rd, ra, rb;
    logic [64:0] trial;
    logic [63:0] res, m, wr;
    logic wen;

    always_comb begin
        ra = '0;
        rb = '0;
        if (32'(dst_reg) < NUM_REGS) ra = rf_reg[dst_reg];
        if (32'(src_reg) < NUM_REGS) rb = rf_reg[src_reg];
        a_rd = (ra >> arfa_pkg::view_shift(dst_view)) & arfa_pkg::view_mask(dst_view);
        b_rd = (rb >> arfa_pkg::view_shift(src_view)) & arfa_pkg::view_mask(src_view);
    end

    assign sts.is_mul = (op_reg == arfa_pkg::OpMul);
    assign sts.is_div = (op_reg == arfa_pkg::OpDiv) || (op_reg == arfa_pkg::OpMod);
    assign sts.div_by_zero = (b_reg == '0);

    // restoring divider step
    assign trial = {rem_reg, quo_reg[63]} - {1'b0, b_reg};

    always_comb begin
        wen = 1'b1;
        case (op_reg)
            arfa_pkg::OpAnd: res = a_reg & b_reg;
            arfa_pkg::OpOr:  res = a_reg | b_reg;
            arfa_pkg::OpXor: res = a_reg ^ b_reg;
            arfa_pkg::OpShl: res = (b_reg >= 64'd64) ? '0 : a_reg << b_reg[5:0];
            arfa_pkg::OpShr: res = (b_reg >= 64'd64) ? '0 : a_reg >> b_reg[5:0];
            arfa_pkg::OpAdd: res = a_reg + b_reg;
            arfa_pkg::OpSub: res = a_reg - b_reg;
            arfa_pkg::OpMul: res = acc_reg;
            arfa_pkg::OpDiv: begin
                res = quo_reg;
                wen = !sts.div_by_zero;
            end
            arfa_pkg::OpMod: begin
                res = rem_reg;
                wen = !sts.div_by_zero;
            end
            arfa_pkg::OpMov: res = b_reg;
            arfa_pkg::OpDec: res = a_reg - 64'd1;
            arfa_pkg::OpInc: res = a_reg + 64'd1;
            arfa_pkg::OpNot: res = ~a_reg;
            default: begin
                res = a_reg;
                wen = 1'b0;
            end
        endcase
        m = arfa_pkg::view_mask(dv_reg);
        wr = (rf_reg[dr_reg < 2'(NUM_REGS) || NUM_REGS > 3 ? dr_reg : 2'd0]
              & ~(m << arfa_pkg::view_shift(dv_reg)))
             | ((res & m) << arfa_pkg::view_shift(dv_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) rf_reg[i] <= '0;
        end else if (cmd.finish && wen && 32'(dr_reg) < NUM_REGS) begin
            rf_reg[dr_reg] <= wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= op;
            dr_reg <= dst_reg;
            dv_reg <= dst_view;
            a_reg <= a_rd;
            b_reg <= b_rd;
            acc_reg <= '0;
            rem_reg <= '0;
            quo_reg <= a_rd;
        end
        if (cmd.mul_step) begin
            // 64x16 slice per cycle, low 64 bits kept
            acc_reg <= acc_reg + ((a_reg * {48'd0, b_reg[15:0]}) << 0);
            a_reg <= a_reg << 16;
            b_reg <= b_reg >> 16;
        end
        if (cmd.div_step) begin
            if (!trial[64]) begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (cmd.finish) begin
            res_value <= wen ? (res & m) : a_reg;
            res_err <= sts.is_div && sts.div_by_zero;
        end
    end
endmodule
`default_nettype wire

// ----- sv/aliased_register_file_alu_unit.sv -----
`default_nettype none
// Executes one register instruction per item over NUM_REGS 64-bit registers,
// each accessed through a view (full, low 32, low 16, low 8, bits 15:8).
// One item is worked at a time. After the accepting edge the controller
// steps through decode, finish and output states for simple ops and for
// div or mod by zero; mul adds four 64x16 partial products and div and mod
// one quotient bit per cycle in the restoring divider. m_valid rises and
// s_ready comes back in the same cycle. The result sits in an output register;
// the next item may be taken while it waits, and that item's result is held
// in the datapath until the output register is free.
// Division by zero leaves the register alone and raises m_div_zero_error.
module aliased_register_file_alu_unit #(
    parameter int unsigned NUM_REGS = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic s_ready,
    input  wire logic [3:0] s_op,
    input  wire logic [1:0] s_dst_reg,
    input  wire logic [2:0] s_dst_view,
    input  wire logic [1:0] s_src_reg,
    input  wire logic [2:0] s_src_view,
    output logic m_valid,
    input  wire logic m_ready,
    output logic [63:0] m_new_value,
    output logic m_div_zero_error
);
    arfa_pkg::arfa_cmd_t cmd;
    arfa_pkg::arfa_sts_t sts;
    logic in_fire, out_load, m_valid_reg;
    logic [63:0] res_value;
    logic res_err;

    assign in_fire = s_valid && s_ready;

    arfa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .out_busy(m_valid_reg && !m_ready), .sts(sts), .cmd(cmd),
        .in_ready(s_ready), .out_load(out_load)
    );

    arfa_dp #(.NUM_REGS(NUM_REGS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .op(s_op),
        .dst_reg(s_dst_reg), .dst_view(s_dst_view), .src_reg(s_src_reg),
        .src_view(s_src_view), .sts(sts), .res_value(res_value), .res_err(res_err)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_new_value <= res_value;
            m_div_zero_error <= res_err;
        end
    end

    assign m_valid = m_valid_reg;

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.mul_step, cmd.div_step, cmd.finish}))
        else $error("more than one datapath command");
    a_err_value: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("result not presented");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step || cmd.mul_step) |-> !s_ready)
        else $error("input accepted while busy");
endmodule
`default_nettype wire
